// File: rtl/phcd_pkg.sv
// ----------------------------------------------------------------------------
// phcd_pkg
// Shared types and constants of the pipe-hex content decoder.
// ----------------------------------------------------------------------------
package phcd_pkg;

    localparam int MAX_CHARS_DEF   = 511;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CNT_W           = 10;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_SPACE  = 2'd1;
    localparam logic [1:0] ERR_BADHEX = 2'd2;
    localparam logic [1:0] ERR_ENDED  = 2'd3;

    // classified character as handed from front to back
    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic       is_pipe;
        logic       is_space;
        logic       is_hex;
        logic [3:0] nibble;
    } phcd_class_t;

    localparam int CLASS_W = $bits(phcd_class_t);

endpackage

// File: rtl/pipe_hex_content_decoder.sv
// ----------------------------------------------------------------------------
// pipe_hex_content_decoder
// Decodes a content string with |xx xx| hex sections, one character per item.
// ----------------------------------------------------------------------------
// Input channel s_*: one character per transfer, s_end_of_string on the last
// character of a string. Result channel m_*: exactly one result per input
// character, in order; m_has_byte flags a produced byte, m_error_code holds
// the latched error, m_done_res marks the result of the last character.
// Throughput is one character per cycle while m_ready is high: the classifier
// register, a short queue (QUEUE_DEPTH entries) and the decode/result register
// each take or give one transfer per cycle. An input character passes the
// classifier register, the queue and the result register to reach m_valid.
// Parse state carries over between characters through the decode stage only.
// When m_ready is low the result register holds, the queue fills and then
// s_ready drops; nothing is lost. After the last character of a string the
// parse state returns to copy mode with the error cleared.
// aresetn (synchronous, active low) empties all stages and clears the parse
// state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pipe_hex_content_decoder #(
    parameter int MAX_CHARS   = phcd_pkg::MAX_CHARS_DEF,
    parameter int QUEUE_DEPTH = phcd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    input  logic       s_end_of_string,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_has_byte,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_error_code,
    output logic       m_done_res
);
    import phcd_pkg::*;

    logic         f_valid;
    logic         f_ready;
    phcd_class_t  f_data;
    logic         q_valid;
    logic         q_ready;
    logic [CLASS_W-1:0] q_data;
    phcd_class_t  q_class;

    phcd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_char       (s_in_char),
        .s_end_of_string (s_end_of_string),
        .push_valid      (f_valid),
        .push_ready      (f_ready),
        .push_data       (f_data)
    );

    phcd_queue #(
        .WIDTH (CLASS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    assign q_class = q_data;

    phcd_back #(
        .MAX_CHARS (MAX_CHARS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (q_valid),
        .pop_ready    (q_ready),
        .pop_data     (q_class),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_has_byte   (m_has_byte),
        .m_out_byte   (m_out_byte),
        .m_error_code (m_error_code),
        .m_done_res   (m_done_res)
    );

`ifndef SYNTH
    // a produced byte never comes with an error
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_has_byte |-> m_error_code == ERR_NONE)
        else $error("byte produced while error latched");

    // zero bytes are dropped
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_has_byte |-> m_out_byte != 8'h00)
        else $error("zero byte produced");

    // no byte means a zero byte field
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_byte |-> m_out_byte == 8'h00)
        else $error("stale byte on empty result");

    // result holds while the receiver stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready
        |=> m_valid && $stable({m_has_byte, m_out_byte, m_error_code, m_done_res}))
        else $error("result changed while stalled");
`endif

endmodule

// File: rtl/phcd_front.sv
// ----------------------------------------------------------------------------
// phcd_front
// Input stage: registers each character together with its classification.
// ----------------------------------------------------------------------------
module phcd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_in_char,
    input  logic                 s_end_of_string,
    output logic                 push_valid,
    input  logic                 push_ready,
    output phcd_pkg::phcd_class_t push_data
);
    import phcd_pkg::*;

    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_SPACE = 8'h20;

    logic         valid_reg;
    phcd_class_t  class_reg;
    phcd_class_t  class_next;

    always_comb begin
        class_next          = '0;
        class_next.ch       = s_in_char;
        class_next.eos      = s_end_of_string;
        class_next.is_pipe  = (s_in_char == CH_PIPE);
        class_next.is_space = (s_in_char == CH_SPACE);
        if (s_in_char >= 8'h30 && s_in_char <= 8'h39) begin
            class_next.is_hex = 1'b1;
            class_next.nibble = 4'(s_in_char - 8'h30);
        end else if (s_in_char >= 8'h41 && s_in_char <= 8'h46) begin
            class_next.is_hex = 1'b1;
            class_next.nibble = 4'(s_in_char - 8'h37);
        end else if (s_in_char >= 8'h61 && s_in_char <= 8'h66) begin
            class_next.is_hex = 1'b1;
            class_next.nibble = 4'(s_in_char - 8'h57);
        end
    end

    assign s_ready    = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_data  = class_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            class_reg <= class_next;
        end
    end

endmodule

// File: rtl/phcd_queue.sv
// ----------------------------------------------------------------------------
// phcd_queue
// Short register queue between the classifier and the decode stage.
// ----------------------------------------------------------------------------
module phcd_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

    logic [WIDTH-1:0]  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (cnt_reg != FULL_CNT);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/phcd_back.sv
// ----------------------------------------------------------------------------
// phcd_back
// Decode stage: pipe/hex parse state, error latch, length limit and the
// result register.
// ----------------------------------------------------------------------------
module phcd_back #(
    parameter int MAX_CHARS = phcd_pkg::MAX_CHARS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  phcd_pkg::phcd_class_t pop_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_has_byte,
    output logic [7:0]            m_out_byte,
    output logic [1:0]            m_error_code,
    output logic                  m_done_res
);
    import phcd_pkg::*;

    typedef enum logic [1:0] {
        MODE_COPY,
        MODE_HIGH,
        MODE_LOW,
        MODE_AFTER
    } mode_t;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHARS);

    mode_t            mode_reg, mode_next, mode_step;
    logic [3:0]       nib_reg, nib_next;
    logic [1:0]       hfault_reg, hfault_next;
    logic [1:0]       err_reg, err_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             valid_reg;
    logic             has_reg, has_next;
    logic [7:0]       byte_reg, byte_next;
    logic [1:0]       code_reg;
    logic             done_reg;

    logic             take;
    logic             active;

    assign pop_ready = !valid_reg || m_ready;
    assign take      = pop_valid && pop_ready;
    assign active    = (err_reg == ERR_NONE) && (cnt_reg < MAX_CNT);

    always_comb begin
        mode_step   = mode_reg;
        nib_next    = nib_reg;
        hfault_next = hfault_reg;
        err_next    = err_reg;
        cnt_next    = cnt_reg;
        has_next    = 1'b0;
        byte_next   = '0;
        if (active) begin
            cnt_next = cnt_reg + 1'b1;
            case (mode_reg)
                MODE_COPY: begin
                    if (pop_data.is_pipe) begin
                        mode_step = MODE_HIGH;
                    end else if (pop_data.ch != '0) begin
                        has_next  = 1'b1;
                        byte_next = pop_data.ch;
                    end
                end
                MODE_HIGH: begin
                    if (pop_data.is_space) begin
                        hfault_next = ERR_SPACE;
                    end else if (!pop_data.is_hex) begin
                        hfault_next = ERR_BADHEX;
                    end else begin
                        hfault_next = ERR_NONE;
                    end
                    nib_next  = pop_data.nibble;
                    mode_step = MODE_LOW;
                end
                MODE_LOW: begin
                    if (hfault_reg == ERR_SPACE || pop_data.is_space) begin
                        err_next = ERR_SPACE;
                    end else if (hfault_reg == ERR_BADHEX || !pop_data.is_hex) begin
                        err_next = ERR_BADHEX;
                    end else if ({nib_reg, pop_data.nibble} != '0) begin
                        has_next  = 1'b1;
                        byte_next = {nib_reg, pop_data.nibble};
                    end
                    mode_step = MODE_AFTER;
                end
                MODE_AFTER: begin
                    mode_step = pop_data.is_pipe ? MODE_COPY : MODE_HIGH;
                end
                default: begin
                    mode_step = MODE_COPY;
                end
            endcase
        end
        mode_next = mode_step;
        // end of string inside hex mode
        if (pop_data.eos && err_next == ERR_NONE) begin
            if (mode_step == MODE_LOW) begin
                err_next = (hfault_next != ERR_NONE) ? hfault_next : ERR_ENDED;
            end else if (mode_step == MODE_HIGH) begin
                err_next = ERR_ENDED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            mode_reg   <= MODE_COPY;
            nib_reg    <= '0;
            hfault_reg <= ERR_NONE;
            err_reg    <= ERR_NONE;
            cnt_reg    <= '0;
        end else begin
            if (pop_ready) begin
                valid_reg <= pop_valid;
            end
            if (take) begin
                if (pop_data.eos) begin
                    mode_reg   <= MODE_COPY;
                    nib_reg    <= '0;
                    hfault_reg <= ERR_NONE;
                    err_reg    <= ERR_NONE;
                    cnt_reg    <= '0;
                end else begin
                    mode_reg   <= mode_next;
                    nib_reg    <= nib_next;
                    hfault_reg <= hfault_next;
                    err_reg    <= err_next;
                    cnt_reg    <= cnt_next;
                end
            end
        end
        if (take) begin
            has_reg  <= has_next;
            byte_reg <= byte_next;
            code_reg <= err_next;
            done_reg <= pop_data.eos;
        end
    end

    assign m_valid      = valid_reg;
    assign m_has_byte   = has_reg;
    assign m_out_byte   = byte_reg;
    assign m_error_code = code_reg;
    assign m_done_res   = done_reg;

endmodule

// File: tb/sv/tb_pipe_hex_content_decoder.sv
// ----------------------------------------------------------------------------
// tb_pipe_hex_content_decoder
// Self-checking bench for the pipe-hex content decoder. Content strings go in
// one character per transfer. A behavioral decoder predicts one result per
// character, and each result transfer is checked against the oldest
// prediction. Directed strings cover the extremes and the error cases.
// Random strings cover hex sections, broken pairs, noise and over-long
// strings. Random idle bursts fall on both sides, and a long result stall
// backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_pipe_hex_content_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import phcd_pkg::*;

    localparam int         CHAR_LIMIT   = MAX_CHARS_DEF;
    localparam int         WATCHDOG_MAX = 2000;
    localparam int         DRAIN_CYCLES = 10;
    localparam logic [7:0] CH_PIPE      = 8'h7C;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    typedef enum logic [1:0] {
        MODE_COPY,
        MODE_HIGH,
        MODE_LOW,
        MODE_AFTER
    } parse_mode_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic [1:0] error_code;
        logic       done_res;
    } decode_result_t;

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_char       = 8'h00;
    logic       s_end_of_string = 1'b0;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic       m_has_byte;
    logic [7:0] m_out_byte;
    logic [1:0] m_error_code;
    logic       m_done_res;

    // decoder state as predicted
    parse_mode_t mode_q       = MODE_COPY;
    logic [3:0]  nibble_q     = 4'h0;
    logic [1:0]  high_fault_q = ERR_NONE;
    logic [1:0]  err_latch_q  = ERR_NONE;
    logic [9:0]  chars_seen   = '0;

    decode_result_t expected_results[$];
    logic [7:0]     content_q[$];

    int  fail_count   = 0;
    int  chars_sent   = 0;
    int  idle_cycles  = 0;
    int  hold_left    = 0;
    int  stall_left   = 0;
    bit  src_idle_en  = 1'b0;
    bit  sink_idle_en = 1'b0;

    pipe_hex_content_decoder uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_char      (s_in_char),
        .s_end_of_string(s_end_of_string),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_has_byte     (m_has_byte),
        .m_out_byte     (m_out_byte),
        .m_error_code   (m_error_code),
        .m_done_res     (m_done_res)
    );

    always begin
        #6;
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
    end

    // bit 4 set when ch is a hex digit, low bits hold its value
    function automatic logic [4:0] hex_digit_value(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") begin
            return {1'b1, 4'(ch - "0")};
        end else if (ch >= "A" && ch <= "F") begin
            return {1'b1, 4'(ch - "A" + 8'd10)};
        end else if (ch >= "a" && ch <= "f") begin
            return {1'b1, 4'(ch - "a" + 8'd10)};
        end
        return 5'b0;
    endfunction

    task automatic decode_char(input logic [7:0] ch, input logic eos);
        decode_result_t res;
        logic [4:0]     hv;
        logic [7:0]     b;
        res = '0;
        if (err_latch_q == ERR_NONE && chars_seen < CHAR_LIMIT) begin
            chars_seen = chars_seen + 10'd1;
            hv = hex_digit_value(ch);
            case (mode_q)
                MODE_COPY: begin
                    if (ch == CH_PIPE) begin
                        mode_q = MODE_HIGH;
                    end else if (ch != 8'h00) begin
                        res.has_byte = 1'b1;
                        res.out_byte = ch;
                    end
                end
                MODE_HIGH: begin
                    if (ch == CH_SPACE) begin
                        high_fault_q = ERR_SPACE;
                    end else if (!hv[4]) begin
                        high_fault_q = ERR_BADHEX;
                    end else begin
                        high_fault_q = ERR_NONE;
                    end
                    nibble_q = hv[4] ? hv[3:0] : 4'h0;
                    mode_q = MODE_LOW;
                end
                MODE_LOW: begin
                    if (high_fault_q == ERR_SPACE || ch == CH_SPACE) begin
                        err_latch_q = ERR_SPACE;
                    end else if (high_fault_q == ERR_BADHEX || !hv[4]) begin
                        err_latch_q = ERR_BADHEX;
                    end else begin
                        b = {nibble_q, hv[3:0]};
                        if (b != 8'h00) begin
                            res.has_byte = 1'b1;
                            res.out_byte = b;
                        end
                    end
                    mode_q = MODE_AFTER;
                end
                default: begin
                    mode_q = (ch == CH_PIPE) ? MODE_COPY : MODE_HIGH;
                end
            endcase
        end
        if (eos && err_latch_q == ERR_NONE) begin
            if (mode_q == MODE_LOW) begin
                err_latch_q = (high_fault_q != ERR_NONE) ? high_fault_q : ERR_ENDED;
            end else if (mode_q == MODE_HIGH) begin
                err_latch_q = ERR_ENDED;
            end
        end
        res.error_code = err_latch_q;
        res.done_res = eos;
        expected_results.push_back(res);
        if (eos) begin
            mode_q = MODE_COPY;
            nibble_q = 4'h0;
            high_fault_q = ERR_NONE;
            err_latch_q = ERR_NONE;
            chars_seen = '0;
        end
    endtask

    always @(posedge aclk) begin
        decode_result_t got;
        decode_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_has_byte, m_out_byte, m_error_code, m_done_res};
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result: has=%0b byte=%02h err=%0d done=%0b",
                             got.has_byte, got.out_byte, got.error_code, got.done_res);
                end
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display({"mismatch: exp has=%0b byte=%02h err=%0d done=%0b,",
                                  " got has=%0b byte=%02h err=%0d done=%0b"},
                                 want.has_byte, want.out_byte, want.error_code,
                                 want.done_res, got.has_byte, got.out_byte,
                                 got.error_code, got.done_res);
                    end
                end
            end
        end
    end

    // result side ready, with random stalls and a forced hold-off
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("tb_pipe_hex_content_decoder NOT OK");
                $finish;
            end
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic eos);
        int gap;
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_char <= ch;
        s_end_of_string <= eos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_char(ch, eos);
        chars_sent++;
    endtask

    task automatic send_content();
        foreach (content_q[i]) begin
            send_char(content_q[i], i == content_q.size() - 1);
        end
    endtask

    task automatic send_text(input string txt);
        content_q.delete();
        for (int i = 0; i < txt.len(); i++) begin
            content_q.push_back(txt[i]);
        end
        send_content();
    endtask

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        return (c == CH_PIPE) ? "x" : c;
    endfunction

    function automatic logic [7:0] digit_char();
        logic [7:0] c;
        logic [4:0] hv;
        int         v;
        if ($urandom_range(0, 11) == 0) begin
            if ($urandom_range(0, 1) == 0) begin
                return CH_SPACE;
            end
            c = 8'($urandom_range(0, 255));
            hv = hex_digit_value(c);
            return hv[4] ? "g" : c;
        end
        v = $urandom_range(0, 15);
        if (v < 10) begin
            return 8'("0" + v);
        end
        return ($urandom_range(0, 1) == 0) ? 8'("a" + v - 10) : 8'("A" + v - 10);
    endfunction

    task automatic make_random_content();
        int n_seg;
        int n_pairs;
        int cut;
        content_q.delete();
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 12)) content_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        n_seg = $urandom_range(1, 4);
        for (int seg = 0; seg < n_seg; seg++) begin
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 6)) content_q.push_back(text_char());
            end else begin
                content_q.push_back(CH_PIPE);
                n_pairs = $urandom_range(1, 4);
                for (int p = 0; p < n_pairs; p++) begin
                    if (p > 0) begin
                        content_q.push_back(($urandom_range(0, 3) == 0) ? text_char() : CH_SPACE);
                    end
                    content_q.push_back(digit_char());
                    content_q.push_back(digit_char());
                end
                if ($urandom_range(0, 7) != 0) begin
                    content_q.push_back(CH_PIPE);
                end
            end
        end
        // cut short now and then so strings end inside hex sections
        if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, content_q.size());
            while (content_q.size() > cut) void'(content_q.pop_back());
        end
    endtask

    task automatic test_directed();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        content_q.delete();
        content_q.push_back(8'h00);
        content_q.push_back("A");
        content_q.push_back(8'hFF);
        send_content();
        send_text("|Fa 00|");
        send_text("| Z!");
        send_text("|4g");
        send_text("|");
        send_text("|g");
        send_text("| ");
        send_text("|41");
    endtask

    task automatic test_random_strings(input int n_chars, input bit idle);
        int target;
        src_idle_en = idle;
        sink_idle_en = idle;
        target = chars_sent + n_chars;
        while (chars_sent < target) begin
            make_random_content();
            send_content();
        end
    endtask

    task automatic test_backpressure();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        hold_left = 80;
        send_text("ab|01 02 7e|cdefgh");
        repeat (3) begin
            make_random_content();
            send_content();
        end
    endtask

    // over-long string that is still inside a pair at the length limit
    task automatic test_long_string();
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        content_q.delete();
        repeat (CHAR_LIMIT - 2) content_q.push_back(text_char());
        content_q.push_back(CH_PIPE);
        content_q.push_back("4");
        repeat (9) content_q.push_back(8'($urandom_range(0, 255)));
        send_content();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_strings(150, 1'b1);
        test_backpressure();
        test_long_string();
        test_random_strings(60, 1'b0);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_pipe_hex_content_decoder OK");
        end else begin
            $display("tb_pipe_hex_content_decoder NOT OK");
        end
        $finish;
    end

endmodule
